// ----- hdl/mfd_pkg.sv -----
`timescale 1ns / 1ps

package mfd_pkg;

    localparam int MOTORS_DEFAULT = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CNT_COEF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_W  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEG_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAD_COEF = 3'd4;

    localparam logic [23:0] CNT_COEF_RST = 24'd737280;
    localparam logic [15:0] SPEED_W_RST  = 16'd32768;
    localparam logic [15:0] CUR_W_RST    = 16'd32768;
    localparam logic [23:0] DEG_COEF_RST = 24'd393216;
    localparam logic [23:0] RAD_COEF_RST = 24'd6863;

    localparam int A_W    = 33;
    localparam int B_W    = 26;
    localparam int PROD_W = A_W + B_W;

    localparam logic [3:0]          MIN_FRAME  = 4'd7;
    localparam logic [16:0]         ONE_Q15    = 17'd32768;
    localparam logic signed [16:0]  WRAP_POS   = 17'sd4096;
    localparam logic signed [16:0]  WRAP_NEG   = -17'sd4096;
    localparam logic signed [B_W-1:0] TURN_Q16 = 26'sd23592960;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_DROP = 4'd14;

    typedef struct packed {
        logic [2:0]         motor_index;
        logic [3:0]         frame_len;
        logic [15:0]        encoder_raw;
        logic signed [15:0] speed_rpm;
        logic signed [15:0] current_raw;
        logic [7:0]         temp_raw;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         motor_echo;
        logic [15:0]        encoder_count;
        logic signed [31:0] single_turn_angle;
        logic signed [31:0] speed_degps;
        logic signed [31:0] speed_radps;
        logic signed [15:0] smoothed_current;
        logic [7:0]         temperature;
        logic signed [31:0] turn_count;
        logic signed [63:0] multi_turn_angle;
    } out_item_t;

    typedef struct packed {
        logic [23:0] cnt_coef;
        logic [15:0] speed_w;
        logic [15:0] cur_w;
        logic [23:0] deg_coef;
        logic [23:0] rad_coef;
    } cfg_t;

    typedef enum logic [3:0] {
        A_ZERO,
        A_ECD,
        A_RPM,
        A_OLD_DEG,
        A_OLD_RAD,
        A_OLD_CUR,
        A_SMP_DEG,
        A_SMP_RAD,
        A_CUR,
        A_TURNS,
        A_ANGLE
    } mul_a_t;

    typedef enum logic [3:0] {
        B_ONE,
        B_CNT_COEF,
        B_DEG_COEF,
        B_RAD_COEF,
        B_WS_NEW,
        B_WS_OLD,
        B_WC_NEW,
        B_WC_OLD,
        B_TURN_Q16
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_KEEP,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_ANGLE,
        ST_SMP_DEG,
        ST_SMP_RAD,
        ST_DEG,
        ST_RAD,
        ST_CUR
    } store_t;

    typedef enum logic {
        JMP_NONE,
        JMP_BAD
    } jmp_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_EMIT,
        FIN_DROP
    } fin_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        mul_a_t             mul_a;
        mul_b_t             mul_b;
        acc_op_t            acc_op;
        store_t             store;
        logic               turn_upd;
        jmp_t               jmp;
        logic [STEP_W-1:0]  jmp_tgt;
        fin_t               fin;
    } ucode_t;

    typedef struct packed {
        logic   exec;
        ucode_t uc;
    } ctl_t;

    typedef struct packed {
        logic bad;
        logic out_free;
    } dp_stat_t;

    // The multiplier result of one step is accumulated in the next step.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc.mul_a    = A_ZERO;
        uc.mul_b    = B_ONE;
        uc.acc_op   = ACC_KEEP;
        uc.store    = ST_NONE;
        uc.turn_upd = 1'b0;
        uc.jmp      = JMP_NONE;
        uc.jmp_tgt  = '0;
        uc.fin      = FIN_NONE;
        case (step)
            4'd0:
            begin
                uc.jmp     = JMP_BAD;
                uc.jmp_tgt = STEP_DROP;
            end
            4'd1:
            begin
                uc.turn_upd = 1'b1;
                uc.mul_a    = A_ECD;
                uc.mul_b    = B_CNT_COEF;
            end
            4'd2:
            begin
                uc.acc_op = ACC_LOAD;
                uc.mul_a  = A_RPM;
                uc.mul_b  = B_DEG_COEF;
            end
            4'd3:
            begin
                uc.store  = ST_ANGLE;
                uc.acc_op = ACC_LOAD;
                uc.mul_a  = A_RPM;
                uc.mul_b  = B_RAD_COEF;
            end
            4'd4:
            begin
                uc.store  = ST_SMP_DEG;
                uc.acc_op = ACC_LOAD;
                uc.mul_a  = A_OLD_DEG;
                uc.mul_b  = B_WS_OLD;
            end
            4'd5:
            begin
                uc.store  = ST_SMP_RAD;
                uc.acc_op = ACC_LOAD;
                uc.mul_a  = A_SMP_DEG;
                uc.mul_b  = B_WS_NEW;
            end
            4'd6:
            begin
                uc.acc_op = ACC_ADD;
                uc.mul_a  = A_OLD_RAD;
                uc.mul_b  = B_WS_OLD;
            end
            4'd7:
            begin
                uc.store  = ST_DEG;
                uc.acc_op = ACC_LOAD;
                uc.mul_a  = A_SMP_RAD;
                uc.mul_b  = B_WS_NEW;
            end
            4'd8:
            begin
                uc.acc_op = ACC_ADD;
                uc.mul_a  = A_OLD_CUR;
                uc.mul_b  = B_WC_OLD;
            end
            4'd9:
            begin
                uc.store  = ST_RAD;
                uc.acc_op = ACC_LOAD;
                uc.mul_a  = A_CUR;
                uc.mul_b  = B_WC_NEW;
            end
            4'd10:
            begin
                uc.acc_op = ACC_ADD;
                uc.mul_a  = A_TURNS;
                uc.mul_b  = B_TURN_Q16;
            end
            4'd11:
            begin
                uc.store  = ST_CUR;
                uc.acc_op = ACC_LOAD;
                uc.mul_a  = A_ANGLE;
                uc.mul_b  = B_ONE;
            end
            4'd12:
            begin
                uc.acc_op = ACC_ADD;
            end
            4'd13:
            begin
                uc.fin = FIN_EMIT;
            end
            default:
            begin
                uc.fin = FIN_DROP;
            end
        endcase
        return uc;
    endfunction

endpackage

// ----- hdl/mfd_sequencer.sv -----
`timescale 1ns / 1ps

module mfd_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  mfd_pkg::dp_stat_t stat,
    output logic             idle,
    output mfd_pkg::ctl_t    ctl
);
    import mfd_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            uc;
    logic              exec;

    always_comb
    begin
        uc   = ucode_rom(step_reg);
        exec = (state_reg == SEQ_RUN) && !((uc.fin == FIN_EMIT) && !stat.out_free);
        idle = (state_reg == SEQ_IDLE);
        ctl.exec = exec;
        ctl.uc   = uc;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = SEQ_RUN;
                    step_next  = '0;
                end
            end
            SEQ_RUN:
            begin
                if (exec)
                begin
                    if (uc.fin != FIN_NONE)
                    begin
                        state_next = SEQ_IDLE;
                    end
                    else if ((uc.jmp == JMP_BAD) && stat.bad)
                    begin
                        step_next = uc.jmp_tgt;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- hdl/mfd_datapath.sv -----
`timescale 1ns / 1ps

module mfd_datapath #(
    parameter int MOTORS = mfd_pkg::MOTORS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  mfd_pkg::in_item_t  in_data,
    input  mfd_pkg::cfg_t      cfg,
    input  mfd_pkg::ctl_t      ctl,
    output mfd_pkg::dp_stat_t  stat,
    output logic               out_valid,
    input  logic               out_ready,
    output mfd_pkg::out_item_t out_data
);
    import mfd_pkg::*;

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    in_item_t                  in_reg;
    logic [MIDX_W+2:0]         idx_wide;
    logic [MIDX_W-1:0]         idx;

    logic [15:0]               prev_reg  [MOTORS];
    logic                      seen_reg  [MOTORS];
    logic signed [31:0]        turns_reg [MOTORS];
    logic signed [31:0]        degps_reg [MOTORS];
    logic signed [31:0]        radps_reg [MOTORS];
    logic signed [15:0]        cur_reg   [MOTORS];

    logic [16:0]               ws_eff;
    logic [16:0]               wc_eff;
    logic signed [A_W-1:0]     op_a;
    logic signed [B_W-1:0]     op_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0]  acc_next;
    logic signed [PROD_W-1:0]  acc_shr;
    logic signed [PROD_W-1:0]  acc_rnd;
    logic signed [PROD_W-1:0]  cur_q;
    logic signed [31:0]        angle_reg;
    logic signed [31:0]        angle_q;
    logic signed [31:0]        smp_deg_reg;
    logic signed [31:0]        smp_rad_reg;
    logic signed [31:0]        sat_q;
    logic signed [16:0]        diff;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_item_t                 out_reg;
    out_item_t                 out_item;

    assign idx_wide = {{MIDX_W{1'b0}}, in_reg.motor_index};
    assign idx      = idx_wide[MIDX_W-1:0];

    assign stat.bad = (in_reg.frame_len < MIN_FRAME) || (int'(in_reg.motor_index) >= MOTORS);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign ws_eff = ({1'b0, cfg.speed_w} > ONE_Q15) ? ONE_Q15 : {1'b0, cfg.speed_w};
    assign wc_eff = ({1'b0, cfg.cur_w} > ONE_Q15) ? ONE_Q15 : {1'b0, cfg.cur_w};

    always_comb
    begin
        case (ctl.uc.mul_a)
            A_ECD:     op_a = {17'b0, in_reg.encoder_raw};
            A_RPM:     op_a = {{17{in_reg.speed_rpm[15]}}, in_reg.speed_rpm};
            A_OLD_DEG: op_a = {degps_reg[idx][31], degps_reg[idx]};
            A_OLD_RAD: op_a = {radps_reg[idx][31], radps_reg[idx]};
            A_OLD_CUR: op_a = {{17{cur_reg[idx][15]}}, cur_reg[idx]};
            A_SMP_DEG: op_a = {smp_deg_reg[31], smp_deg_reg};
            A_SMP_RAD: op_a = {smp_rad_reg[31], smp_rad_reg};
            A_CUR:     op_a = {{17{in_reg.current_raw[15]}}, in_reg.current_raw};
            A_TURNS:   op_a = {turns_reg[idx][31], turns_reg[idx]};
            A_ANGLE:   op_a = {angle_reg[31], angle_reg};
            default:   op_a = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.uc.mul_b)
            B_CNT_COEF: op_b = {2'b00, cfg.cnt_coef};
            B_DEG_COEF: op_b = {2'b00, cfg.deg_coef};
            B_RAD_COEF: op_b = {2'b00, cfg.rad_coef};
            B_WS_NEW:   op_b = {9'b0, ws_eff};
            B_WS_OLD:   op_b = {9'b0, ONE_Q15 - ws_eff};
            B_WC_NEW:   op_b = {9'b0, wc_eff};
            B_WC_OLD:   op_b = {9'b0, ONE_Q15 - wc_eff};
            B_TURN_Q16: op_b = TURN_Q16;
            default:    op_b = 26'sd1;
        endcase
    end

    assign prod_next = op_a * op_b;

    always_comb
    begin
        case (ctl.uc.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        angle_q = acc_reg[39] ? 32'sh7FFF_FFFF : $signed(acc_reg[39:8]);
        if ((&acc_reg[PROD_W-1:31]) || !(|acc_reg[PROD_W-1:31]))
        begin
            sat_q = acc_reg[31:0];
        end
        else
        begin
            sat_q = acc_reg[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        acc_shr = acc_reg >>> 15;
        acc_rnd = acc_reg[PROD_W-1] ? acc_reg + $signed(PROD_W'(32767)) : acc_reg;
        cur_q   = acc_rnd >>> 15;
        diff    = $signed({1'b0, in_reg.encoder_raw}) - $signed({1'b0, prev_reg[idx]});
    end

    always_comb
    begin
        out_item.motor_echo        = in_reg.motor_index;
        out_item.encoder_count     = in_reg.encoder_raw;
        out_item.single_turn_angle = angle_reg;
        out_item.speed_degps       = degps_reg[idx];
        out_item.speed_radps       = radps_reg[idx];
        out_item.smoothed_current  = cur_reg[idx];
        out_item.temperature       = in_reg.temp_raw;
        out_item.turn_count        = turns_reg[idx];
        out_item.multi_turn_angle  = {{(64-PROD_W){acc_reg[PROD_W-1]}}, acc_reg};
    end

    always_comb
    begin
        if (ctl.exec && (ctl.uc.fin == FIN_EMIT))
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                prev_reg[i]  <= '0;
                seen_reg[i]  <= 1'b0;
                turns_reg[i] <= '0;
                degps_reg[i] <= '0;
                radps_reg[i] <= '0;
                cur_reg[i]   <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                if (ctl.uc.turn_upd)
                begin
                    if (seen_reg[idx])
                    begin
                        if (diff > WRAP_POS)
                        begin
                            turns_reg[idx] <= turns_reg[idx] - 32'sd1;
                        end
                        else if (diff < WRAP_NEG)
                        begin
                            turns_reg[idx] <= turns_reg[idx] + 32'sd1;
                        end
                    end
                    prev_reg[idx] <= in_reg.encoder_raw;
                    seen_reg[idx] <= 1'b1;
                end
                case (ctl.uc.store)
                    ST_DEG:  degps_reg[idx] <= acc_shr[31:0];
                    ST_RAD:  radps_reg[idx] <= acc_shr[31:0];
                    ST_CUR:  cur_reg[idx]   <= cur_q[15:0];
                    default:
                    begin
                    end
                endcase
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= in_data;
        end
        if (ctl.exec)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            if (ctl.uc.store == ST_ANGLE)
            begin
                angle_reg <= angle_q;
            end
            if (ctl.uc.store == ST_SMP_DEG)
            begin
                smp_deg_reg <= sat_q;
            end
            if (ctl.uc.store == ST_SMP_RAD)
            begin
                smp_rad_reg <= sat_q;
            end
            if (ctl.uc.fin == FIN_EMIT)
            begin
                out_reg <= out_item;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hdl/motor_feedback_decoder.sv -----
`timescale 1ns / 1ps

// Channel    Handshake              Payload      Width
// input      in_valid / in_ready    in_data      in_item_t
// output     out_valid / out_ready  out_data     out_item_t
// config     cfg_wr_en              cfg_index    cfg_data (24 bits)
//
// A full frame runs 14 microcode steps on the one shared 33 x 26 multiplier,
// and no new frame is taken until the frame in progress has finished.
// A short frame or an unknown motor index jumps from the first step to the drop step.
// Reset clears the configuration to its defaults and every motor's state to zero.
// The emit step waits while the output register still holds an untaken result.
module motor_feedback_decoder #(
    parameter int MOTORS = mfd_pkg::MOTORS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mfd_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mfd_pkg::out_item_t               out_data,
    input  logic                             cfg_wr_en,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mfd_pkg::*;

    cfg_t     cfg_reg;
    logic     in_fire;
    logic     idle;
    ctl_t     ctl;
    dp_stat_t stat;

    assign in_ready = idle;
    assign in_fire  = in_valid && idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cnt_coef <= CNT_COEF_RST;
            cfg_reg.speed_w  <= SPEED_W_RST;
            cfg_reg.cur_w    <= CUR_W_RST;
            cfg_reg.deg_coef <= DEG_COEF_RST;
            cfg_reg.rad_coef <= RAD_COEF_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CNT_COEF: cfg_reg.cnt_coef <= cfg_data;
                CFG_SPEED_W:  cfg_reg.speed_w  <= cfg_data[15:0];
                CFG_CUR_W:    cfg_reg.cur_w    <= cfg_data[15:0];
                CFG_DEG_COEF: cfg_reg.deg_coef <= cfg_data;
                CFG_RAD_COEF: cfg_reg.rad_coef <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mfd_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .stat    (stat),
        .idle    (idle),
        .ctl     (ctl)
    );

    mfd_datapath #(
        .MOTORS (MOTORS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a frame is in progress");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a frame in progress");

    a_angle_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_data.single_turn_angle[31])
        else $error("single-turn angle is negative");

    a_multi_turn_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.multi_turn_angle ==
            64'(out_data.turn_count) * 64'(TURN_Q16) + 64'(out_data.single_turn_angle))
        else $error("multi-turn angle does not match turns and single-turn angle");

endmodule
